[rtl/clps_pkg.sv]
// Shared types and constants for the clipped line pixel stepper.
package clps_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_POINT = 3'd1,
    MODE_VERT  = 3'd2,
    MODE_HORIZ = 3'd3,
    MODE_XMAJ  = 3'd4,
    MODE_YMAJ  = 3'd5
  } mode_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam int          SCREEN_BITS  = 12;
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  // one step yields at most this many pixels
  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic write_enable;
    logic step_last;
    logic line_done;
  } res_flags_t;

endpackage

[rtl/clps_engine.sv]
// Line state, screen registers and the per-item load/step logic.
module clps_engine
  import clps_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [SCREEN_BITS-1:0]       cfg_wdata,
  input  logic                         fire,
  input  logic                         item_cmd,
  input  logic signed [COORD_BITS-1:0] item_sx,
  input  logic signed [COORD_BITS-1:0] item_sy,
  input  logic signed [COORD_BITS-1:0] item_ex,
  input  logic signed [COORD_BITS-1:0] item_ey,
  input  logic [31:0]                  item_color,
  output logic [1:0]                   res_cnt,
  output logic signed [COORD_BITS-1:0] res_x [MAX_RESULTS],
  output logic signed [COORD_BITS-1:0] res_y [MAX_RESULTS],
  output res_flags_t                   res_flags [MAX_RESULTS],
  output logic [31:0]                  res_color
);

  localparam int CB = COORD_BITS;
  localparam int CW = (CB > SCREEN_BITS) ? CB : SCREEN_BITS;

  mode_t                mode_r, mode_nxt;
  logic signed [CB-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CB-1:0] end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  logic [CB-1:0]        major_len_r, major_len_nxt, minor_len_r, minor_len_nxt;
  logic [CB:0]          err_r, err_nxt;
  logic                 minor_dir_r, minor_dir_nxt, major_dir_r, major_dir_nxt;
  logic [31:0]          color_r, color_nxt;
  logic [SCREEN_BITS-1:0] scr_w_r, scr_w_nxt, scr_h_r, scr_h_nxt;

  logic                 done;

  function automatic logic signed [CB-1:0] step1(input logic signed [CB-1:0] v,
                                                 input logic down);
    step1 = down ? (v - CB'(1)) : (v + CB'(1));
  endfunction

  function automatic logic on_screen(input logic signed [CB-1:0] x,
                                     input logic signed [CB-1:0] y,
                                     input logic [SCREEN_BITS-1:0] w,
                                     input logic [SCREEN_BITS-1:0] h);
    on_screen = !x[CB-1] && !y[CB-1] &&
                (CW'(unsigned'(x)) < CW'(w)) && (CW'(unsigned'(y)) < CW'(h));
  endfunction

  // load decode
  logic          ld_same_x, ld_same_y, ld_xmaj, ld_swap;
  logic [CB-1:0] ld_dx, ld_dy;
  logic signed [CB-1:0] ld_x1, ld_y1, ld_x2, ld_y2;

  assign ld_same_x = (item_sx == item_ex);
  assign ld_same_y = (item_sy == item_ey);
  assign ld_dx     = (item_sx < item_ex) ? (item_ex - item_sx) : (item_sx - item_ex);
  assign ld_dy     = (item_sy < item_ey) ? (item_ey - item_sy) : (item_sy - item_ey);
  assign ld_xmaj   = (ld_dx >= ld_dy);
  assign ld_swap   = !ld_same_x && !ld_same_y &&
                     (ld_xmaj ? (item_ex < item_sx) : (item_ey < item_sy));
  assign ld_x1     = ld_swap ? item_ex : item_sx;
  assign ld_y1     = ld_swap ? item_ey : item_sy;
  assign ld_x2     = ld_swap ? item_sx : item_ex;
  assign ld_y2     = ld_swap ? item_sy : item_ey;

  // slope step: error update, minor move, then endpoint test
  logic [CB:0]          err_sum, err_step;
  logic                 minor_move, xmaj, slope_end;
  logic signed [CB-1:0] mx, my;

  assign err_sum    = err_r + {1'b0, minor_len_r};
  assign minor_move = (err_sum >= {1'b0, major_len_r});
  assign err_step   = minor_move ? (err_sum - {1'b0, major_len_r}) : err_sum;
  assign xmaj       = (mode_r == MODE_XMAJ);
  assign mx         = (!xmaj && minor_move) ? step1(cur_x_r, minor_dir_r) : cur_x_r;
  assign my         = (xmaj && minor_move) ? step1(cur_y_r, minor_dir_r) : cur_y_r;
  assign slope_end  = xmaj ? (mx == end_x_r) : (my == end_y_r);

  logic signed [CB-1:0] px [MAX_RESULTS];
  logic signed [CB-1:0] py [MAX_RESULTS];

  always_comb begin
    mode_nxt      = mode_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    end_x_nxt     = end_x_r;
    end_y_nxt     = end_y_r;
    major_len_nxt = major_len_r;
    minor_len_nxt = minor_len_r;
    err_nxt       = err_r;
    minor_dir_nxt = minor_dir_r;
    major_dir_nxt = major_dir_r;
    color_nxt     = color_r;
    scr_w_nxt     = scr_w_r;
    scr_h_nxt     = scr_h_r;
    res_cnt       = 2'd0;
    done          = 1'b0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      px[i] = cur_x_r;
      py[i] = cur_y_r;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_nxt = cfg_wdata;
        REG_SCREEN_HEIGHT: scr_h_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (fire) begin
      unique case (item_cmd)
        CMD_LOAD: begin
          color_nxt     = item_color;
          err_nxt       = '0;
          major_dir_nxt = 1'b0;
          minor_dir_nxt = 1'b0;
          cur_x_nxt     = ld_x1;
          cur_y_nxt     = ld_y1;
          end_x_nxt     = ld_x2;
          end_y_nxt     = ld_y2;
          if (ld_same_x && ld_same_y) begin
            mode_nxt = MODE_POINT;
          end else if (ld_same_x) begin
            mode_nxt      = MODE_VERT;
            major_dir_nxt = (item_sy > item_ey);
          end else if (ld_same_y) begin
            mode_nxt      = MODE_HORIZ;
            major_dir_nxt = (item_sx > item_ex);
          end else if (ld_xmaj) begin
            mode_nxt      = MODE_XMAJ;
            major_len_nxt = ld_dx;
            minor_len_nxt = ld_dy;
            minor_dir_nxt = (ld_y2 < ld_y1);
          end else begin
            mode_nxt      = MODE_YMAJ;
            major_len_nxt = ld_dy;
            minor_len_nxt = ld_dx;
            minor_dir_nxt = (ld_x2 < ld_x1);
          end
        end
        CMD_STEP: begin
          case (mode_r)
            MODE_POINT: begin
              res_cnt = 2'd1;
              done    = 1'b1;
            end
            MODE_VERT: begin
              res_cnt = 2'd1;
              if (cur_y_r == end_y_r) done = 1'b1;
              else cur_y_nxt = step1(cur_y_r, major_dir_r);
            end
            MODE_HORIZ: begin
              res_cnt = 2'd1;
              if (cur_x_r == end_x_r) done = 1'b1;
              else cur_x_nxt = step1(cur_x_r, major_dir_r);
            end
            MODE_XMAJ, MODE_YMAJ: begin
              res_cnt = 2'd1 + 2'(minor_move) + 2'(slope_end);
              err_nxt = err_step;
              px[1]   = minor_move ? mx : end_x_r;
              py[1]   = minor_move ? my : end_y_r;
              px[2]   = end_x_r;
              py[2]   = end_y_r;
              if (slope_end) begin
                done      = 1'b1;
                cur_x_nxt = mx;
                cur_y_nxt = my;
              end else begin
                cur_x_nxt = xmaj ? step1(mx, 1'b0) : mx;
                cur_y_nxt = xmaj ? my : step1(my, 1'b0);
              end
            end
            default: ;
          endcase
          if (done) mode_nxt = MODE_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_x[i]                  = px[i];
      res_y[i]                  = py[i];
      res_flags[i].write_enable = on_screen(px[i], py[i], scr_w_r, scr_h_r);
      res_flags[i].step_last    = (2'(i + 1) == res_cnt);
      res_flags[i].line_done    = done && (2'(i + 1) == res_cnt);
    end
  end

  assign res_color = color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      scr_w_r <= WIDTH_RESET;
      scr_h_r <= HEIGHT_RESET;
    end else begin
      mode_r  <= mode_nxt;
      scr_w_r <= scr_w_nxt;
      scr_h_r <= scr_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    end_x_r     <= end_x_nxt;
    end_y_r     <= end_y_nxt;
    major_len_r <= major_len_nxt;
    minor_len_r <= minor_len_nxt;
    err_r       <= err_nxt;
    minor_dir_r <= minor_dir_nxt;
    major_dir_r <= major_dir_nxt;
    color_r     <= color_nxt;
  end

endmodule

[rtl/clps_result_queue.sv]
// Three-slot shifting result buffer that drains one pixel per transfer.
module clps_result_queue
  import clps_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [1:0]                   push_cnt,
  input  logic signed [COORD_BITS-1:0] push_x [MAX_RESULTS],
  input  logic signed [COORD_BITS-1:0] push_y [MAX_RESULTS],
  input  res_flags_t                   push_flags [MAX_RESULTS],
  input  logic [31:0]                  push_color,
  output logic                         can_take,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic signed [COORD_BITS-1:0] q_x,
  output logic signed [COORD_BITS-1:0] q_y,
  output logic [31:0]                  q_color,
  output res_flags_t                   q_flags
);

  logic [1:0]                   cnt_r, cnt_nxt;
  logic signed [COORD_BITS-1:0] slot_x_r [MAX_RESULTS];
  logic signed [COORD_BITS-1:0] slot_y_r [MAX_RESULTS];
  res_flags_t                   slot_f_r [MAX_RESULTS];
  logic [31:0]                  color_r;
  logic                         pop;

  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  // room for a whole step's worth once the last pending pixel goes out
  assign can_take = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && q_ready);

  assign q_x     = slot_x_r[0];
  assign q_y     = slot_y_r[0];
  assign q_flags = slot_f_r[0];
  assign q_color = color_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) cnt_nxt = push_cnt;
    else if (pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      color_r <= push_color;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        slot_x_r[i] <= push_x[i];
        slot_y_r[i] <= push_y[i];
        slot_f_r[i] <= push_flags[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot_x_r[i] <= slot_x_r[i+1];
        slot_y_r[i] <= slot_y_r[i+1];
        slot_f_r[i] <= slot_f_r[i+1];
      end
    end
  end

endmodule

[rtl/clipped_line_pixel_stepper.sv]
// Top level of the clipped line pixel stepper: input register, line engine, result buffer.
//
// A load item (in_tuser = 0) latches two endpoints and a color and produces no
// pixel; a step item (in_tuser = 1) advances one position along the major axis
// and yields one to three pixels, the last of a step flagged by out_tlast and
// the last of the line by out_tuser[1]. Pixels off the screen set by the
// screen_width/screen_height registers come out with out_tuser[0] low. An item
// is registered on input and its pixels are computed from that register into a
// three-entry result buffer, which offers them on the single result port one
// per transfer. Loads and steps on an idle line yield no pixel and leave the
// port free; the next item enters as the last pixel of a drawing step goes out.
module clipped_line_pixel_stepper
  import clps_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // start_x, start_y, stop_x, stop_y, line_color, zero fill
  input  logic [((4*COORD_BITS+32+7)/8)*8-1:0]       in_tdata,
  // command
  input  logic                                       in_tuser,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*COORD_BITS+32+7)/8)*8-1:0]       out_tdata,
  // write_enable, line_done
  output logic [1:0]                                 out_tuser,
  output logic                                       out_tlast,
  input  logic                                       cfg_we,
  input  logic                                       cfg_index,
  input  logic [SCREEN_BITS-1:0]                     cfg_wdata
);

  localparam int CB    = COORD_BITS;
  localparam int OUT_W = ((2*CB+32+7)/8)*8;

  logic                 in_valid_r;
  logic                 in_cmd_r;
  logic signed [CB-1:0] in_sx_r, in_sy_r, in_ex_r, in_ey_r;
  logic [31:0]          in_color_r;

  logic                 can_take, fire;
  logic [1:0]           eng_cnt;
  logic signed [CB-1:0] eng_x [MAX_RESULTS];
  logic signed [CB-1:0] eng_y [MAX_RESULTS];
  res_flags_t           eng_flags [MAX_RESULTS];
  logic [31:0]          eng_color;

  logic signed [CB-1:0] q_x, q_y;
  logic [31:0]          q_color;
  res_flags_t           q_flags;

  assign fire      = in_valid_r && can_take;
  assign in_tready = !in_valid_r || can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else if (in_tready) in_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r   <= in_tuser;
      in_sx_r    <= in_tdata[CB-1:0];
      in_sy_r    <= in_tdata[2*CB-1:CB];
      in_ex_r    <= in_tdata[3*CB-1:2*CB];
      in_ey_r    <= in_tdata[4*CB-1:3*CB];
      in_color_r <= in_tdata[4*CB+31:4*CB];
    end
  end

  clps_engine #(
    .COORD_BITS(COORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item_cmd  (in_cmd_r),
    .item_sx   (in_sx_r),
    .item_sy   (in_sy_r),
    .item_ex   (in_ex_r),
    .item_ey   (in_ey_r),
    .item_color(in_color_r),
    .res_cnt   (eng_cnt),
    .res_x     (eng_x),
    .res_y     (eng_y),
    .res_flags (eng_flags),
    .res_color (eng_color)
  );

  clps_result_queue #(
    .COORD_BITS(COORD_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && (eng_cnt != 2'd0)),
    .push_cnt  (eng_cnt),
    .push_x    (eng_x),
    .push_y    (eng_y),
    .push_flags(eng_flags),
    .push_color(eng_color),
    .can_take  (can_take),
    .q_valid   (out_tvalid),
    .q_ready   (out_tready),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_color   (q_color),
    .q_flags   (q_flags)
  );

  assign out_tdata = OUT_W'({q_color, q_y, q_x});
  assign out_tuser = {q_flags.line_done, q_flags.write_enable};
  assign out_tlast = q_flags.step_last;

`ifndef SYNTH
  // a step that yields pixels must show one on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (eng_cnt != 2'd0) |=> out_tvalid)
    else $error("computed pixels did not reach the output");

  // the end of a line is always the end of its step
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("line_done without step_last");

  // negative columns are never written
  a_neg_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[CB-1] |-> !out_tuser[0])
    else $error("write enable on a negative column");
`endif

endmodule
